FILE: rtl/pfr_pkg.sv
// Shared types and constants for the page frame replacement table.
package pfr_pkg;

    localparam int STAT_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int FRAMES_W    = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES = 1'b1;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_FINISH
    } pfr_state_t;

    typedef struct packed {
        logic hit;
        logic fault;
        logic writeback;
    } pfr_event_t;

endpackage

FILE: rtl/pfr_stats.sv
// Saturating hit, fault and write-back counters.
module pfr_stats
    import pfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pfr_event_t        ev,
    output logic [STAT_W-1:0] hit_total,
    output logic [STAT_W-1:0] fault_total,
    output logic [STAT_W-1:0] write_total
);

    logic [STAT_W-1:0] hit_cnt_reg;
    logic [STAT_W-1:0] hit_cnt_next;
    logic [STAT_W-1:0] fault_cnt_reg;
    logic [STAT_W-1:0] fault_cnt_next;
    logic [STAT_W-1:0] wb_cnt_reg;
    logic [STAT_W-1:0] wb_cnt_next;

    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        wb_cnt_next    = wb_cnt_reg;
        if (ev.hit && (hit_cnt_reg != '1))
        begin
            hit_cnt_next = hit_cnt_reg + STAT_W'(1);
        end
        if (ev.fault && (fault_cnt_reg != '1))
        begin
            fault_cnt_next = fault_cnt_reg + STAT_W'(1);
        end
        if (ev.writeback && (wb_cnt_reg != '1))
        begin
            wb_cnt_next = wb_cnt_reg + STAT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            wb_cnt_reg    <= '0;
        end
        else
        begin
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            wb_cnt_reg    <= wb_cnt_next;
        end
    end

    assign hit_total   = hit_cnt_reg;
    assign fault_total = fault_cnt_reg;
    assign write_total = wb_cnt_reg;

endmodule

FILE: rtl/page_frame_replacement.sv
// Page frame replacement table: slot memory, scan sequencer and result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  access   | start, busy            | vpn, is_write, timestamp
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//  result   | done (one-cycle beat)  | hit, victim_valid, victim_page,
//           |                        | victim_dirty, hit_total, fault_total,
//           |                        | write_total
//
// One slot is read per cycle from a single-port-read slot memory. An access scans
// the used slots, stopping at a hit; second chance on a full table then adds a
// clear sweep of the used slots. done follows.
// Reset empties the table through the fill count; no clearing pass is needed.
// Results cannot be stalled; a new access may start in the done cycle.
module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int FRAMES    = 64,
    parameter int PAGE_BITS = 20,
    parameter int TIME_BITS = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_BITS-1:0]   vpn,
    input  logic                   is_write,
    input  logic [TIME_BITS-1:0]   timestamp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   done,
    output logic                   hit,
    output logic                   victim_valid,
    output logic [PAGE_BITS-1:0]   victim_page,
    output logic                   victim_dirty,
    output logic [STAT_W-1:0]      hit_total,
    output logic [STAT_W-1:0]      fault_total,
    output logic [STAT_W-1:0]      write_total
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (CNT_W > FRAMES_W) ? CNT_W : FRAMES_W;
    localparam int ENT_W = PAGE_BITS + TIME_BITS + 2;

    pfr_state_t state_reg;
    pfr_state_t state_next;

    logic                  policy_reg;
    logic                  policy_next;
    logic [FRAMES_W-1:0]   frames_reg;
    logic [FRAMES_W-1:0]   frames_next;
    logic [CNT_W-1:0]      used_count_reg;
    logic [CNT_W-1:0]      used_count_next;

    logic [PAGE_BITS-1:0]  req_page_reg;
    logic [PAGE_BITS-1:0]  req_page_next;
    logic                  req_wr_reg;
    logic                  req_wr_next;
    logic [TIME_BITS-1:0]  req_time_reg;
    logic [TIME_BITS-1:0]  req_time_next;

    logic [CNT_W-1:0]      issue_idx_reg;
    logic [CNT_W-1:0]      issue_idx_next;
    logic                  chk_vld_reg;
    logic                  chk_vld_next;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic [IDX_W-1:0]      chk_idx_next;

    logic                  best_vld_reg;
    logic                  best_vld_next;
    logic [TIME_BITS-1:0]  best_key_reg;
    logic [TIME_BITS-1:0]  best_key_next;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [IDX_W-1:0]      best_idx_next;
    logic [PAGE_BITS-1:0]  best_page_reg;
    logic [PAGE_BITS-1:0]  best_page_next;
    logic                  best_dirty_reg;
    logic                  best_dirty_next;

    logic [IDX_W-1:0]      tgt_idx_reg;
    logic [IDX_W-1:0]      tgt_idx_next;
    logic                  tgt_hit_reg;
    logic                  tgt_hit_next;
    logic                  tgt_dirty_reg;
    logic                  tgt_dirty_next;
    logic                  tgt_evict_reg;
    logic                  tgt_evict_next;

    logic                  done_reg;
    logic                  done_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  vvalid_reg;
    logic                  vvalid_next;
    logic [PAGE_BITS-1:0]  vpage_reg;
    logic [PAGE_BITS-1:0]  vpage_next;
    logic                  vdirty_reg;
    logic                  vdirty_next;

    logic [ENT_W-1:0]      slot_mem [FRAMES];
    logic [ENT_W-1:0]      mem_q_reg;
    logic                  mem_re;
    logic                  mem_we;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;

    logic [PAGE_BITS-1:0]  q_page;
    logic [TIME_BITS-1:0]  q_time;
    logic                  q_ref;
    logic                  q_dirty;
    logic [TIME_BITS-1:0]  cand_key;
    logic                  cand_better;
    logic                  issue_more;
    logic                  sweep_hit;
    logic                  cap_room;

    pfr_event_t            ev;

    assign q_page  = mem_q_reg[ENT_W-1 -: PAGE_BITS];
    assign q_time  = mem_q_reg[2 +: TIME_BITS];
    assign q_ref   = mem_q_reg[1];
    assign q_dirty = mem_q_reg[0];

    // second chance: a referenced slot ranks as if moved to the current time
    assign cand_key    = (policy_reg && q_ref && (req_time_reg > q_time)) ? req_time_reg
                                                                          : q_time;
    assign cand_better = !best_vld_reg || (cand_key < best_key_reg);
    assign issue_more  = issue_idx_reg < used_count_reg;
    // referenced slots ranked ahead of the victim get moved to the back
    assign sweep_hit   = q_ref && (chk_idx_reg != best_idx_reg) &&
                         ((q_time < best_key_reg) ||
                          ((q_time == best_key_reg) && (chk_idx_reg < best_idx_reg)));
    assign cap_room    = (frames_reg == '0) ? (used_count_reg == '0) :
                         ((CMP_W'(used_count_reg) < CMP_W'(frames_reg)) &&
                          (used_count_reg < CNT_W'(FRAMES)));

    always_comb
    begin
        policy_next = policy_reg;
        frames_next = frames_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLICY: policy_next = cfg_data[0];
                CFG_FRAMES: frames_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        used_count_next = used_count_reg;
        req_page_next   = req_page_reg;
        req_wr_next     = req_wr_reg;
        req_time_next   = req_time_reg;
        issue_idx_next  = issue_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        best_vld_next   = best_vld_reg;
        best_key_next   = best_key_reg;
        best_idx_next   = best_idx_reg;
        best_page_next  = best_page_reg;
        best_dirty_next = best_dirty_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_hit_next    = tgt_hit_reg;
        tgt_dirty_next  = tgt_dirty_reg;
        tgt_evict_next  = tgt_evict_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        vvalid_next     = vvalid_reg;
        vpage_next      = vpage_reg;
        vdirty_next     = vdirty_reg;
        mem_re          = 1'b0;
        rd_addr         = issue_idx_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_data         = {q_page, req_time_reg, 1'b0, q_dirty};
        ev              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_page_next  = vpn;
                    req_wr_next    = is_write;
                    req_time_next  = timestamp;
                    best_vld_next  = 1'b0;
                    mem_re         = used_count_reg != '0;
                    rd_addr        = '0;
                    issue_idx_next = CNT_W'(1);
                    chk_idx_next   = '0;
                    chk_vld_next   = used_count_reg != '0;
                    state_next     = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                if (chk_vld_reg)
                begin
                    if (q_page == req_page_reg)
                    begin
                        tgt_hit_next   = 1'b1;
                        tgt_idx_next   = chk_idx_reg;
                        tgt_dirty_next = q_dirty | req_wr_reg;
                        tgt_evict_next = 1'b0;
                        chk_vld_next   = 1'b0;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        if (cand_better)
                        begin
                            best_vld_next   = 1'b1;
                            best_key_next   = cand_key;
                            best_idx_next   = chk_idx_reg;
                            best_page_next  = q_page;
                            best_dirty_next = q_dirty;
                        end
                        mem_re         = issue_more;
                        chk_vld_next   = issue_more;
                        chk_idx_next   = issue_idx_reg[IDX_W-1:0];
                        issue_idx_next = issue_more ? issue_idx_reg + CNT_W'(1)
                                                    : issue_idx_reg;
                    end
                end
                else
                begin
                    tgt_hit_next   = 1'b0;
                    tgt_dirty_next = req_wr_reg;
                    if (cap_room)
                    begin
                        tgt_idx_next   = used_count_reg[IDX_W-1:0];
                        tgt_evict_next = 1'b0;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        tgt_idx_next   = best_idx_reg;
                        tgt_evict_next = 1'b1;
                        if (policy_reg)
                        begin
                            mem_re         = 1'b1;
                            rd_addr        = '0;
                            issue_idx_next = CNT_W'(1);
                            chk_idx_next   = '0;
                            chk_vld_next   = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                if (chk_vld_reg)
                begin
                    mem_we         = sweep_hit;
                    mem_re         = issue_more;
                    chk_vld_next   = issue_more;
                    chk_idx_next   = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_more ? issue_idx_reg + CNT_W'(1) : issue_idx_reg;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                mem_we       = 1'b1;
                wr_addr      = tgt_idx_reg;
                wr_data      = {req_page_reg, req_time_reg, tgt_hit_reg, tgt_dirty_reg};
                ev.hit       = tgt_hit_reg;
                ev.fault     = !tgt_hit_reg;
                ev.writeback = tgt_evict_reg && best_dirty_reg;
                if (!tgt_hit_reg && !tgt_evict_reg)
                begin
                    used_count_next = used_count_reg + CNT_W'(1);
                end
                hit_next    = tgt_hit_reg;
                vvalid_next = tgt_evict_reg;
                vpage_next  = tgt_evict_reg ? best_page_reg : '0;
                vdirty_next = tgt_evict_reg && best_dirty_reg;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            policy_reg     <= 1'b0;
            frames_reg     <= FRAMES_RESET;
            used_count_reg <= '0;
            chk_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            frames_reg     <= frames_next;
            used_count_reg <= used_count_next;
            chk_vld_reg    <= chk_vld_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_page_reg   <= req_page_next;
        req_wr_reg     <= req_wr_next;
        req_time_reg   <= req_time_next;
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        best_vld_reg   <= best_vld_next;
        best_key_reg   <= best_key_next;
        best_idx_reg   <= best_idx_next;
        best_page_reg  <= best_page_next;
        best_dirty_reg <= best_dirty_next;
        tgt_idx_reg    <= tgt_idx_next;
        tgt_hit_reg    <= tgt_hit_next;
        tgt_dirty_reg  <= tgt_dirty_next;
        tgt_evict_reg  <= tgt_evict_next;
        hit_reg        <= hit_next;
        vvalid_reg     <= vvalid_next;
        vpage_reg      <= vpage_next;
        vdirty_reg     <= vdirty_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            mem_q_reg <= slot_mem[rd_addr];
        end
    end

    pfr_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .hit_total   (hit_total),
        .fault_total (fault_total),
        .write_total (write_total)
    );

    assign busy         = state_reg != ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign victim_valid = vvalid_reg;
    assign victim_page  = vpage_reg;
    assign victim_dirty = vdirty_reg;

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result beat without a finish cycle");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_W'(FRAMES))
        else $error("fill count beyond table depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (wr_addr != rd_addr))
        else $error("slot read and write to the same entry");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("slot write while idle");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(hit_reg && vvalid_reg))
        else $error("hit and eviction in one beat");

endmodule

FILE: sim/page_frame_replacement_tb.sv
// Self-checking testbench for page_frame_replacement against a shadow table.
module page_frame_replacement_tb;
    import pfr_pkg::*;

    localparam int FRAMES     = 64;
    localparam int PAGE_BITS  = 20;
    localparam int TIME_BITS  = 31;
    localparam int POOL_SIZE  = 96;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 160;
    localparam int CYCLE_CAP  = 1500000;

    localparam bit POLICY_LRU           = 1'b0;
    localparam bit POLICY_SECOND_CHANCE = 1'b1;

    typedef struct packed {
        logic                 hit;
        logic                 victim_valid;
        logic [PAGE_BITS-1:0] victim_page;
        logic                 victim_dirty;
        logic [STAT_W-1:0]    hit_total;
        logic [STAT_W-1:0]    fault_total;
        logic [STAT_W-1:0]    write_total;
    } page_outcome_t;

    class frame_table_tracker;
        bit                   policy;
        bit [CFG_DATA_W-1:0]  frame_limit;
        bit                   live[FRAMES];
        bit [PAGE_BITS-1:0]   tag[FRAMES];
        bit [TIME_BITS-1:0]   stamp[FRAMES];
        bit                   referenced[FRAMES];
        bit                   dirty[FRAMES];
        int                   used;
        bit [STAT_W-1:0]      hits;
        bit [STAT_W-1:0]      faults;
        bit [STAT_W-1:0]      writebacks;
        page_outcome_t        outcomes_due[$];
        int                   mismatches;

        function new();
            int i;
            policy      = POLICY_LRU;
            frame_limit = FRAMES_RESET;
            for (i = 0; i < FRAMES; i++)
            begin
                live[i]       = 1'b0;
                tag[i]        = '0;
                stamp[i]      = '0;
                referenced[i] = 1'b0;
                dirty[i]      = 1'b0;
            end
            used        = 0;
            hits        = '0;
            faults      = '0;
            writebacks  = '0;
            mismatches  = 0;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_POLICY)
                policy = data[0];
            else
                frame_limit = data;
        endfunction

        function bit [STAT_W-1:0] bump(bit [STAT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function int oldest();
            int i, best;
            best = -1;
            for (i = 0; i < FRAMES; i++)
            begin
                if (live[i] && (best < 0 || stamp[i] < stamp[best]))
                    best = i;
            end
            return best;
        endfunction

        function void fill(int s, bit [PAGE_BITS-1:0] page, bit wr, bit [TIME_BITS-1:0] ts);
            live[s]       = 1'b1;
            tag[s]        = page;
            stamp[s]      = ts;
            referenced[s] = 1'b0;
            dirty[s]      = wr;
        endfunction

        function void note_access(logic [PAGE_BITS-1:0] page, logic wr, logic [TIME_BITS-1:0] ts);
            page_outcome_t o;
            int i, r, found, cap, v;
            o = '0;
            found = -1;
            for (i = 0; i < FRAMES; i++)
            begin
                if (found < 0 && live[i] && tag[i] == page)
                    found = i;
            end
            if (found >= 0)
            begin
                o.hit = 1'b1;
                hits = bump(hits);
                stamp[found] = ts;
                referenced[found] = 1'b1;
                if (wr)
                    dirty[found] = 1'b1;
            end
            else
            begin
                faults = bump(faults);
                cap = (frame_limit == 0) ? 1 : (frame_limit > FRAMES) ? FRAMES : frame_limit;
                if (used < cap)
                begin
                    v = -1;
                    for (i = 0; i < FRAMES; i++)
                    begin
                        if (v < 0 && !live[i])
                            v = i;
                    end
                    if (v >= 0)
                    begin
                        fill(v, page, wr, ts);
                        used++;
                    end
                end
                else
                begin
                    v = oldest();
                    if (policy == POLICY_SECOND_CHANCE)
                    begin
                        // referenced victim gets moved to the back and the search runs again
                        for (r = 0; r < FRAMES && v >= 0 && referenced[v]; r++)
                        begin
                            referenced[v] = 1'b0;
                            stamp[v] = ts;
                            v = oldest();
                        end
                    end
                    if (v >= 0)
                    begin
                        o.victim_valid = 1'b1;
                        o.victim_page  = tag[v];
                        o.victim_dirty = dirty[v];
                        if (dirty[v])
                            writebacks = bump(writebacks);
                        fill(v, page, wr, ts);
                    end
                end
            end
            o.hit_total   = hits;
            o.fault_total = faults;
            o.write_total = writebacks;
            outcomes_due.push_back(o);
        endfunction

        function void compare_field(string name, logic [STAT_W-1:0] want, logic [STAT_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_outcome(page_outcome_t got);
            page_outcome_t want;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result beat with no access outstanding, got %0h", $time, got);
                mismatches++;
                return;
            end
            want = outcomes_due.pop_front();
            compare_field("hit", STAT_W'(want.hit), STAT_W'(got.hit));
            compare_field("victim_valid", STAT_W'(want.victim_valid),
                          STAT_W'(got.victim_valid));
            compare_field("victim_page", STAT_W'(want.victim_page), STAT_W'(got.victim_page));
            compare_field("victim_dirty", STAT_W'(want.victim_dirty),
                          STAT_W'(got.victim_dirty));
            compare_field("hit_total", want.hit_total, got.hit_total);
            compare_field("fault_total", want.fault_total, got.fault_total);
            compare_field("write_total", want.write_total, got.write_total);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [PAGE_BITS-1:0]   vpn = '0;
    logic                   is_write = 1'b0;
    logic [TIME_BITS-1:0]   timestamp = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   done;
    logic                   hit;
    logic                   victim_valid;
    logic [PAGE_BITS-1:0]   victim_page;
    logic                   victim_dirty;
    logic [STAT_W-1:0]      hit_total;
    logic [STAT_W-1:0]      fault_total;
    logic [STAT_W-1:0]      write_total;

    frame_table_tracker     table_shadow;
    int                     cycles = 0;
    bit [PAGE_BITS-1:0]     page_pool[POOL_SIZE];
    bit [TIME_BITS-1:0]     ts_now;

    page_frame_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .TIME_BITS (TIME_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vpn          (vpn),
        .is_write     (is_write),
        .timestamp    (timestamp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .hit          (hit),
        .victim_valid (victim_valid),
        .victim_page  (victim_page),
        .victim_dirty (victim_dirty),
        .hit_total    (hit_total),
        .fault_total  (fault_total),
        .write_total  (write_total)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("[page_frame_replacement] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        page_outcome_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                table_shadow.write_register(cfg_index, cfg_data);
            if (start && !busy)
                table_shadow.note_access(vpn, is_write, timestamp);
            if (done)
            begin
                seen = {hit, victim_valid, victim_page, victim_dirty,
                        hit_total, fault_total, write_total};
                table_shadow.check_outcome(seen);
            end
        end
    end

    task automatic send_access(bit [PAGE_BITS-1:0] pg, bit wr, bit [TIME_BITS-1:0] ts);
        start       <= 1'b1;
        vpn         <= pg;
        is_write    <= wr;
        timestamp   <= ts;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic sender_pause(bit after_busy, int gap);
        start <= 1'b0;
        if (after_busy)
        begin
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
        repeat (gap) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (table_shadow.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(bit pol, bit [CFG_DATA_W-1:0] frames);
        drain();
        // only bit 0 of the policy word counts; upper bits are noise
        cfg_write(CFG_POLICY, (CFG_DATA_W'($urandom) & 7'h7E) | CFG_DATA_W'(pol));
        cfg_write(CFG_FRAMES, frames);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int ph, n, i, cap, k;
        int frame_menu[PHASES];
        bit [PAGE_BITS-1:0] pg;
        bit wr;

        table_shadow = new();
        frame_menu = '{2, 64, 1, 32, 0, 127, 4, 16, 63, 65, 8, 64};
        for (i = 0; i < POOL_SIZE; i++)
            page_pool[i] = PAGE_BITS'($urandom);
        page_pool[0] = '0;
        page_pool[1] = '1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: LRU over the full table
        send_access(20'h00000, 1'b0, 31'd0);
        send_access(20'hFFFFF, 1'b1, 31'h7FFFFFFF);
        send_access(20'h00000, 1'b1, 31'd5);
        send_access(20'hFFFFF, 1'b0, 31'd6);

        // capacity of zero behaves as one, below the resident count
        configure(POLICY_LRU, 7'd0);
        send_access(20'h12345, 1'b0, 31'd7);
        send_access(20'hFFFFF, 1'b1, 31'd8);
        send_access(20'hABCDE, 1'b0, 31'd9);

        // capacity above the table size behaves as the full table
        configure(POLICY_SECOND_CHANCE, 7'd127);
        send_access(20'h00001, 1'b1, 31'd10);
        send_access(20'h00002, 1'b0, 31'd10);

        configure(POLICY_SECOND_CHANCE, 7'd2);
        send_access(20'h00001, 1'b0, 31'd11);
        send_access(20'hFFFFF, 1'b0, 31'd11);
        send_access(20'h00002, 1'b1, 31'd11);
        send_access(20'h12345, 1'b0, 31'd11);
        send_access(20'h55555, 1'b1, 31'd12);
        send_access(20'h55555, 1'b0, 31'd12);
        send_access(20'h2AAAA, 1'b0, 31'd13);
        send_access(20'h00001, 1'b1, 31'd14);

        configure(POLICY_LRU, 7'd1);
        send_access(20'h33333, 1'b1, 31'd20);
        send_access(20'h44444, 1'b0, 31'd20);
        send_access(20'h44444, 1'b1, 31'd20);

        ts_now = 31'd100;
        for (ph = 0; ph < PHASES; ph++)
        begin
            cap = frame_menu[ph];
            if (cap == 0)
                cap = 1;
            if (cap > FRAMES)
                cap = FRAMES;
            k = cap + $urandom_range(0, cap / 2 + 2);
            if (k > POOL_SIZE)
                k = POOL_SIZE;
            configure(ph[0], CFG_DATA_W'(frame_menu[ph]));
            if (ph == 6)
                ts_now = 31'h7FFFFF00;
            for (n = 0; n < PHASE_LEN; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    pg = PAGE_BITS'($urandom);
                else
                    pg = page_pool[$urandom_range(0, k - 1)];
                wr = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 31) == 0)
                    ts_now = TIME_BITS'($urandom);
                else
                    ts_now = ts_now + TIME_BITS'($urandom_range(0, 3));
                send_access(pg, wr, ts_now);
                if (ph < PHASES - 2 && (n / 32) % 2 == 0 && $urandom_range(0, 3) == 0)
                    sender_pause(1'($urandom_range(0, 1)), $urandom_range(1, 7));
            end
        end

        drain();
        if (table_shadow.mismatches == 0)
            $display("[page_frame_replacement] OK");
        else
            $display("[page_frame_replacement] ERROR");
        $finish;
    end

endmodule
